/* hdl/lcb_pkg.sv */
// Package for the binary-lifting common ancestor block.
// Holds node types, item codes, sequencer states and the read request struct.
// Used by every module of the block; depends on nothing.
package lcb_pkg;

  localparam int NODE_W        = 10;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_TOP_LEVEL = 10;

  typedef logic [NODE_W-1:0] node_t;

  localparam logic MODE_ATTACH = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ATT,
    ST_ATT_WR,
    ST_Q_DEP,
    ST_Q_LIFT,
    ST_Q_CMP,
    ST_Q_WALK,
    ST_Q_FIN
  } st_t;

  // Read request to both ports of the tree store.
  typedef struct packed {
    logic  en;
    node_t a;
    node_t b;
  } rd_req_t;

endpackage

/* hdl/lca_binary_lifting_top.sv */
// Top level of the binary-lifting common ancestor block.
// Instantiates lcb_seq and lcb_store and holds the result register; uses lcb_pkg.
//
// The block keeps a rooted tree (node 1 the root, node 0 a sentinel above it)
// as one ancestor row and one depth per node. After reset it clears every node
// of the store, one node per cycle, before it takes the first beat.
// An attach beat (mode 0) hangs first_node under second_node in these steps:
// the state that takes the beat, one step per ancestor level above the parent
// and one row write.
// A query beat (mode 1) answers the lowest common ancestor of the two nodes in
// these steps: the state that takes the beat, one depth read of both nodes,
// one lift step per level, one compare, one walk step per level and a final
// read, each step one pass through the dual-read store. When the lifted node
// already meets the other, the walk is skipped. One item is worked at a time; a
// finished result waits in the output register while the next beat is taken,
// and a result that finds the register still full holds the block until it
// empties.
module lca_binary_lifting_top #(
  parameter int MAX_NODES = lcb_pkg::DEF_MAX_NODES,
  parameter int TOP_LEVEL = lcb_pkg::DEF_TOP_LEVEL
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic           mode,
  input  lcb_pkg::node_t first_node,
  input  lcb_pkg::node_t second_node,
  output logic           resp_valid,
  input  logic           resp_ready,
  output lcb_pkg::node_t ancestor_node
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int ROW_W = (TOP_LEVEL + 1) * lcb_pkg::NODE_W;

  lcb_pkg::rd_req_t rd;
  logic [ROW_W-1:0] row_a, row_b, wr_row;
  lcb_pkg::node_t   dep_a, dep_b, wr_depth, res_node;
  logic [AW-1:0]    wr_addr;
  logic             wr_en, res_load, res_room;

  assign res_room = !resp_valid || resp_ready;

  lcb_seq #(
    .MAX_NODES(MAX_NODES),
    .TOP_LEVEL(TOP_LEVEL)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .mode       (mode),
    .first_node (first_node),
    .second_node(second_node),
    .res_room   (res_room),
    .res_load   (res_load),
    .res_node   (res_node),
    .rd         (rd),
    .row_a      (row_a),
    .row_b      (row_b),
    .dep_a      (dep_a),
    .dep_b      (dep_b),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_row     (wr_row),
    .wr_depth   (wr_depth)
  );

  lcb_store #(
    .MAX_NODES(MAX_NODES),
    .TOP_LEVEL(TOP_LEVEL)
  ) u_store (
    .clk     (clk),
    .rd      (rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .wr_depth(wr_depth),
    .row_a   (row_a),
    .row_b   (row_b),
    .dep_a   (dep_a),
    .dep_b   (dep_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (res_load) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) ancestor_node <= res_node;
  end

endmodule

/* hdl/lcb_store.sv */
// Tree store: ancestor rows (one word per node) and node depths.
// One write port, two registered read ports; out-of-range nodes read as zero.
// Depends on lcb_pkg.
module lcb_store #(
  parameter int MAX_NODES = lcb_pkg::DEF_MAX_NODES,
  parameter int TOP_LEVEL = lcb_pkg::DEF_TOP_LEVEL,
  localparam int AW    = $clog2(MAX_NODES),
  localparam int ROW_W = (TOP_LEVEL + 1) * lcb_pkg::NODE_W
) (
  input  logic             clk,
  input  lcb_pkg::rd_req_t rd,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_row,
  input  lcb_pkg::node_t   wr_depth,
  output logic [ROW_W-1:0] row_a,
  output logic [ROW_W-1:0] row_b,
  output lcb_pkg::node_t   dep_a,
  output lcb_pkg::node_t   dep_b
);

  logic [ROW_W-1:0] row_mem [MAX_NODES];
  lcb_pkg::node_t   dep_mem [MAX_NODES];

  logic [ROW_W-1:0] row_a_q, row_b_q;
  lcb_pkg::node_t   dep_a_q, dep_b_q;
  logic             ok_a, ok_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
      dep_mem[wr_addr] <= wr_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      row_a_q <= row_mem[AW'(rd.a)];
      row_b_q <= row_mem[AW'(rd.b)];
      dep_a_q <= dep_mem[AW'(rd.a)];
      dep_b_q <= dep_mem[AW'(rd.b)];
      ok_a    <= 32'(rd.a) < 32'(MAX_NODES);
      ok_b    <= 32'(rd.b) < 32'(MAX_NODES);
    end
  end

  // Nodes beyond the table have no row; they read as a cleared entry.
  assign row_a = ok_a ? row_a_q : '0;
  assign row_b = ok_b ? row_b_q : '0;
  assign dep_a = ok_a ? dep_a_q : '0;
  assign dep_b = ok_b ? dep_b_q : '0;

endmodule

/* hdl/lcb_seq.sv */
// Sequencer and node registers for attach and query items.
// Steps one lifting level per cycle through the shared store read ports.
// Depends on lcb_pkg; drives lcb_store.
module lcb_seq #(
  parameter int MAX_NODES = lcb_pkg::DEF_MAX_NODES,
  parameter int TOP_LEVEL = lcb_pkg::DEF_TOP_LEVEL,
  localparam int AW    = $clog2(MAX_NODES),
  localparam int LW    = $clog2(TOP_LEVEL + 1),
  localparam int ROW_W = (TOP_LEVEL + 1) * lcb_pkg::NODE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              mode,
  input  lcb_pkg::node_t    first_node,
  input  lcb_pkg::node_t    second_node,
  input  logic              res_room,
  output logic              res_load,
  output lcb_pkg::node_t    res_node,
  output lcb_pkg::rd_req_t  rd,
  input  logic [ROW_W-1:0]  row_a,
  input  logic [ROW_W-1:0]  row_b,
  input  lcb_pkg::node_t    dep_a,
  input  lcb_pkg::node_t    dep_b,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [ROW_W-1:0]  wr_row,
  output lcb_pkg::node_t    wr_depth
);

  localparam int W = lcb_pkg::NODE_W;
  localparam logic [LW-1:0] LVL_TOP = LW'(TOP_LEVEL);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_NODES - 1);

  lcb_pkg::st_t   state, state_next;
  logic [LW-1:0]  lvl, lvl_next;
  lcb_pkg::node_t a, a_next;
  lcb_pkg::node_t b, b_next;
  lcb_pkg::node_t gap, gap_next;
  lcb_pkg::node_t dep, dep_next;
  logic [ROW_W-1:0] row_buf, row_buf_next;
  logic [AW-1:0]  clr_idx, clr_idx_next;
  logic           hit, hit_next;

  logic [LW-1:0]  lvl_dn;
  lcb_pkg::node_t mid, att_val, na, nb;
  logic [31:0]    gap_sh;

  always_comb begin
    lvl_dn  = lvl - 1'b1;
    mid     = row_buf[lvl_dn*W +: W];
    // An attach under itself reads back the entry just built, which is the child.
    att_val = (mid == b) ? mid : row_a[lvl_dn*W +: W];
    na      = row_a[lvl*W +: W];
    nb      = row_b[lvl*W +: W];
    gap_sh  = 32'(gap) >> lvl;
  end

  always_comb begin
    state_next = state;
    case (state)
      lcb_pkg::ST_CLEAR:  if (clr_idx == CLR_LAST) state_next = lcb_pkg::ST_IDLE;
      lcb_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (mode == lcb_pkg::MODE_QUERY) ? lcb_pkg::ST_Q_DEP : lcb_pkg::ST_ATT;
        end
      end
      lcb_pkg::ST_ATT:    if (lvl == LVL_TOP) state_next = lcb_pkg::ST_ATT_WR;
      lcb_pkg::ST_ATT_WR: state_next = lcb_pkg::ST_IDLE;
      lcb_pkg::ST_Q_DEP:  state_next = lcb_pkg::ST_Q_LIFT;
      lcb_pkg::ST_Q_LIFT: if (lvl == LVL_TOP) state_next = lcb_pkg::ST_Q_CMP;
      lcb_pkg::ST_Q_CMP:  state_next = (a == b) ? lcb_pkg::ST_Q_FIN : lcb_pkg::ST_Q_WALK;
      lcb_pkg::ST_Q_WALK: if (lvl == '0) state_next = lcb_pkg::ST_Q_FIN;
      lcb_pkg::ST_Q_FIN:  if (res_room) state_next = lcb_pkg::ST_IDLE;
      default:            state_next = lcb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    lvl_next     = lvl;
    a_next       = a;
    b_next       = b;
    gap_next     = gap;
    dep_next     = dep;
    row_buf_next = row_buf;
    clr_idx_next = clr_idx;
    hit_next     = hit;
    req_ready    = 1'b0;
    res_load     = 1'b0;
    res_node     = hit ? a : row_a[W-1:0];
    wr_en        = 1'b0;
    wr_addr      = AW'(b);
    wr_row       = row_buf;
    wr_depth     = dep;
    rd.en        = (state != lcb_pkg::ST_CLEAR);
    case (state)
      lcb_pkg::ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_row       = '0;
        wr_depth     = '0;
        clr_idx_next = clr_idx + 1'b1;
      end
      lcb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          hit_next = 1'b0;
          if (mode == lcb_pkg::MODE_QUERY) begin
            a_next   = first_node;
            b_next   = second_node;
            lvl_next = '0;
          end else begin
            // Attach keeps the walking ancestor in a and the child in b.
            a_next             = second_node;
            b_next             = first_node;
            row_buf_next[W-1:0] = second_node;
            lvl_next           = LW'(1);
          end
        end
      end
      lcb_pkg::ST_ATT: begin
        row_buf_next[lvl*W +: W] = att_val;
        a_next = att_val;
        if (lvl == LW'(1)) dep_next = dep_a + 1'b1;
        lvl_next = lvl + 1'b1;
      end
      lcb_pkg::ST_ATT_WR: begin
        wr_en = 32'(b) < 32'(MAX_NODES);
      end
      lcb_pkg::ST_Q_DEP: begin
        if (dep_a < dep_b) begin
          a_next   = b;
          b_next   = a;
          gap_next = dep_b - dep_a;
        end else begin
          gap_next = dep_a - dep_b;
        end
      end
      lcb_pkg::ST_Q_LIFT: begin
        if (gap_sh[0]) a_next = na;
        lvl_next = (lvl == LVL_TOP) ? LVL_TOP : lvl + 1'b1;
      end
      lcb_pkg::ST_Q_CMP: begin
        hit_next = (a == b);
      end
      lcb_pkg::ST_Q_WALK: begin
        if (na != nb) begin
          a_next = na;
          b_next = nb;
        end
        lvl_next = lvl - 1'b1;
      end
      lcb_pkg::ST_Q_FIN: begin
        res_load = res_room;
      end
      default: begin
      end
    endcase
    // Outside the clear, the store always holds the rows of the nodes in a and b for the next step.
    rd.a = a_next;
    rd.b = b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lcb_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl     <= lvl_next;
    a       <= a_next;
    b       <= b_next;
    gap     <= gap_next;
    dep     <= dep_next;
    row_buf <= row_buf_next;
    hit     <= hit_next;
  end

endmodule

/* hdl/lcb_checker.sv */
// Port-level checks for the common ancestor block, bound to its top level.
// Depends on lcb_pkg and on the ports of lca_binary_lifting_top.
module lcb_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           mode,
  input logic           resp_valid,
  input logic           resp_ready,
  input lcb_pkg::node_t ancestor_node
);

  // The store is cleared after reset before any beat is taken.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken while the store is being cleared");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(ancestor_node))
    else $error("response dropped or changed while stalled");

  // An item keeps the block busy after its beat is taken, so no beat follows right after another.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 !req_ready)
    else $error("request taken while an item is still in work");

  // No result appears right after a beat is taken; an attach gives none at all.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !resp_valid |=> !resp_valid ##1 !resp_valid)
    else $error("result appeared too early");

  a_attach_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && mode == lcb_pkg::MODE_ATTACH && !resp_valid
    |=> ##2 !resp_valid)
    else $error("attach produced a result");

endmodule

bind lca_binary_lifting_top lcb_checker u_lcb_checker (.*);

/* sim/lca_checker.sv */
// Checker for the binary-lifting common ancestor block: watches both channels,
// keeps its own copy of the ancestor rows and depths, and compares every answer.
// Depends on lcb_pkg for the node type, the mode codes and the default sizes.
`timescale 1ns / 100ps

module lca_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  logic           mode,
  input  lcb_pkg::node_t first_node,
  input  lcb_pkg::node_t second_node,
  input  logic           resp_valid,
  input  logic           resp_ready,
  input  lcb_pkg::node_t ancestor_node,
  output int             errors,
  output int             outstanding
);

  localparam int LEVELS = lcb_pkg::DEF_TOP_LEVEL + 1;

  lcb_pkg::node_t up_table [lcb_pkg::DEF_MAX_NODES][LEVELS];
  lcb_pkg::node_t depth_of [lcb_pkg::DEF_MAX_NODES];
  lcb_pkg::node_t lca_expected [$];

  function automatic void hang_node(input lcb_pkg::node_t child,
                                    input lcb_pkg::node_t parent);
    lcb_pkg::node_t mid;
    int             j;
    depth_of[child] = depth_of[parent] + 1'b1;
    up_table[child][0] = parent;
    // Each level reads the row as it stands, so a node hung under itself
    // sees its own freshly written entries.
    for (j = 1; j < LEVELS; j++) begin
      mid = up_table[child][j-1];
      up_table[child][j] = up_table[mid][j-1];
    end
  endfunction

  function automatic lcb_pkg::node_t common_root(input lcb_pkg::node_t a,
                                                 input lcb_pkg::node_t b);
    lcb_pkg::node_t x;
    lcb_pkg::node_t y;
    lcb_pkg::node_t gap;
    lcb_pkg::node_t nx;
    lcb_pkg::node_t ny;
    int             j;
    if (depth_of[a] < depth_of[b]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    gap = depth_of[x] - depth_of[y];
    for (j = 0; j < LEVELS && j < lcb_pkg::NODE_W; j++) begin
      if (gap[j]) x = up_table[x][j];
    end
    if (x == y) return x;
    for (j = LEVELS - 1; j >= 0; j--) begin
      nx = up_table[x][j];
      ny = up_table[y][j];
      if (nx != ny) begin
        x = nx;
        y = ny;
      end
    end
    return up_table[x][0];
  endfunction

  always @(posedge clk) begin : watch
    int             n;
    int             j;
    lcb_pkg::node_t want;
    if (rst) begin
      for (n = 0; n < lcb_pkg::DEF_MAX_NODES; n++) begin
        depth_of[n] = '0;
        for (j = 0; j < LEVELS; j++) up_table[n][j] = '0;
      end
      lca_expected.delete();
      errors = 0;
      outstanding <= 0;
    end else begin
      if (resp_valid && resp_ready) begin
        if (lca_expected.size() == 0) begin
          $error("ancestor_node: beat with no query waiting, expected none, actual %0d",
                 ancestor_node);
          errors++;
        end else begin
          want = lca_expected.pop_front();
          if (ancestor_node !== want) begin
            $error("ancestor_node mismatch: expected %0d, actual %0d", want, ancestor_node);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) begin
        if (mode == lcb_pkg::MODE_ATTACH) hang_node(first_node, second_node);
        else lca_expected = {lca_expected, common_root(first_node, second_node)};
      end
      outstanding <= lca_expected.size();
    end
  end

endmodule

/* sim/testbench.sv */
// Top of the common ancestor testbench: clock, reset, stimulus and verdict.
// Instantiates lca_binary_lifting_top and lca_checker; uses lcb_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 600000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  logic           mode = lcb_pkg::MODE_ATTACH;
  lcb_pkg::node_t first_node = '0;
  lcb_pkg::node_t second_node = '0;
  logic           resp_valid;
  logic           resp_ready = 1'b0;
  lcb_pkg::node_t ancestor_node;

  int errors;
  int outstanding;
  int cycles = 0;
  bit pace_on = 1'b1;
  bit calm = 1'b0;
  int stall_left = 0;
  int tall [lcb_pkg::DEF_MAX_NODES];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lca_binary_lifting_top uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .mode         (mode),
    .first_node   (first_node),
    .second_node  (second_node),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .ancestor_node(ancestor_node)
  );

  lca_checker check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .mode         (mode),
    .first_node   (first_node),
    .second_node  (second_node),
    .resp_valid   (resp_valid),
    .resp_ready   (resp_ready),
    .ancestor_node(ancestor_node),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: a random stall after every beat, with calm stretches.
  always @(posedge clk) begin
    if (rst) begin
      resp_ready <= 1'b0;
      stall_left = 0;
    end else if (resp_valid && resp_ready) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall_left = calm ? 0 : $urandom_range(0, 12);
      resp_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      resp_ready <= (stall_left == 0);
    end else begin
      resp_ready <= 1'b1;
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic m, input lcb_pkg::node_t a, input lcb_pkg::node_t b);
    int gap;
    if ($urandom_range(0, 59) == 0) pace_on = !pace_on;
    gap = pace_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    mode        <= m;
    first_node  <= a;
    second_node <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic attach_beat(input lcb_pkg::node_t child, input lcb_pkg::node_t parent);
    send_beat(lcb_pkg::MODE_ATTACH, child, parent);
    tall[child] = (tall[parent] + 1) % lcb_pkg::DEF_MAX_NODES;
  endtask

  task automatic query_beat(input lcb_pkg::node_t a, input lcb_pkg::node_t b);
    send_beat(lcb_pkg::MODE_QUERY, a, b);
  endtask

  // Hold the request side until every pending answer has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    lcb_pkg::node_t fresh [lcb_pkg::DEF_MAX_NODES-2];
    lcb_pkg::node_t grown [$];
    lcb_pkg::node_t members [$];
    bit             in_tree [lcb_pkg::DEF_MAX_NODES];
    lcb_pkg::node_t child;
    lcb_pkg::node_t parent;
    lcb_pkg::node_t tmp;
    lcb_pkg::node_t a;
    lcb_pkg::node_t b;
    lcb_pkg::node_t last;
    int             idx;
    int             k;
    int             r;
    int             extra;
    int             target;
    int             added;
    bit             wrapped;
    bit             paused;
    bit             bushy;

    foreach (tall[n]) tall[n] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty tree: root against itself, root against sentinel, stray nodes; then a small tree with re-hangs.
    query_beat(10'd1, 10'd1);
    query_beat(10'd0, 10'd1);
    query_beat(10'd1023, 10'd0);
    attach_beat(10'd2, 10'd1);
    attach_beat(10'd3, 10'd1);
    attach_beat(10'd4, 10'd2);
    attach_beat(10'd5, 10'd4);
    attach_beat(10'd8, 10'd3);
    query_beat(10'd5, 10'd8);
    query_beat(10'd5, 10'd4);
    query_beat(10'd4, 10'd5);
    query_beat(10'd2, 10'd2);
    query_beat(10'd5, 10'd1);
    query_beat(10'd1023, 10'd5);
    attach_beat(10'd7, 10'd0);
    query_beat(10'd7, 10'd5);
    attach_beat(10'd6, 10'd6);
    query_beat(10'd6, 10'd5);
    attach_beat(10'd4, 10'd3);
    query_beat(10'd5, 10'd8);
    attach_beat(10'd1023, 10'd5);
    attach_beat(10'd9, 10'd1023);
    query_beat(10'd9, 10'd8);
    query_beat(10'd1023, 10'd1023);
    drain();

    // Deep phase: a long spine from the root with occasional side branches.
    // Once fresh nodes run out, old ones are hung again under the spine tip
    // until the depth counter has wrapped past its top value; the wrapping hang and nineteen more end it.
    for (k = 0; k < lcb_pkg::DEF_MAX_NODES - 2; k++) fresh[k] = lcb_pkg::node_t'(k + 2);
    for (k = lcb_pkg::DEF_MAX_NODES - 3; k > 0; k--) begin
      r = $urandom_range(0, k);
      tmp = fresh[k];
      fresh[k] = fresh[r];
      fresh[r] = tmp;
    end
    grown = {grown, 10'd1};
    last = 10'd1;
    idx = 0;
    extra = 0;
    wrapped = 1'b0;
    paused = 1'b0;
    while (extra < 20) begin
      if ($urandom_range(0, 4) == 0) begin
        a = grown[$urandom_range(0, grown.size() - 1)];
        if ($urandom_range(0, 7) == 0) begin
          b = lcb_pkg::node_t'($urandom_range(0, lcb_pkg::DEF_MAX_NODES - 1));
        end else begin
          b = grown[$urandom_range(0, grown.size() - 1)];
        end
        query_beat(a, b);
      end else begin
        if (idx < lcb_pkg::DEF_MAX_NODES - 2) begin
          child = fresh[idx];
          idx++;
          grown = {grown, child};
        end else begin
          child = grown[$urandom_range(1, grown.size() - 1)];
        end
        if ($urandom_range(0, 15) == 0) begin
          attach_beat(child, grown[$urandom_range(0, grown.size() - 1)]);
        end else begin
          attach_beat(child, last);
          last = child;
          if (tall[child] == 0) wrapped = 1'b1;
        end
        if (wrapped) extra++;
      end
      if (idx == 500 && !paused) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();

    // Fresh well-formed trees, each parent hung before its children, salted with noise and bad parents.
    for (k = 0; k < 5; k++) begin
      foreach (in_tree[n]) in_tree[n] = 1'b0;
      members.delete();
      members = {members, 10'd1};
      in_tree[1] = 1'b1;
      target = $urandom_range(10, 50);
      bushy = $urandom_range(0, 1);
      added = 0;
      while (added < target) begin
        r = $urandom_range(0, 47);
        if (r < 3) begin
          send_beat(1'($urandom_range(0, 1)),
                    lcb_pkg::node_t'($urandom_range(0, lcb_pkg::DEF_MAX_NODES - 1)),
                    lcb_pkg::node_t'($urandom_range(0, lcb_pkg::DEF_MAX_NODES - 1)));
        end else if (r < 19) begin
          a = members[$urandom_range(0, members.size() - 1)];
          if (r == 18) b = lcb_pkg::node_t'($urandom_range(0, 1) ? 0 : $urandom_range(0, 1023));
          else b = members[$urandom_range(0, members.size() - 1)];
          query_beat(a, b);
        end else begin
          do child = lcb_pkg::node_t'($urandom_range(2, lcb_pkg::DEF_MAX_NODES - 1));
          while (in_tree[child]);
          if (r < 21) begin
            parent = lcb_pkg::node_t'($urandom_range(0, lcb_pkg::DEF_MAX_NODES - 1));
          end else if (bushy) begin
            parent = members[$urandom_range(0, members.size() - 1)];
          end else begin
            parent = members[members.size() - 1];
          end
          attach_beat(child, parent);
          members = {members, child};
          in_tree[child] = 1'b1;
          added++;
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lcb_pkg.sv
hdl/lcb_store.sv
hdl/lcb_seq.sv
hdl/lca_binary_lifting_top.sv
hdl/lcb_checker.sv
sim/lca_checker.sv
sim/testbench.sv
